// File: sv/sbr_pkg.sv
// Shared types and constants of the stream byte reassembler.
package sbr_pkg;

  // Reassembly window size in bytes (2 to 64).
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int POS_W    = 32;
  localparam int BYTE_W   = 8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Input operation codes.
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_code_t;

  // Shared index adder operations.
  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    pos_t    a;
    pos_t    b;
  } alu_req_t;

  typedef struct packed {
    pos_t sum;
    logic carry;
  } alu_rsp_t;

endpackage

// File: sv/sbr_if.sv
// Valid/ready channel interfaces for the input and result words.
interface sbr_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        position;
  logic [7:0]         data_byte;
  logic               final_byte;

  modport source (output valid, output operation, output position, output data_byte,
                  output final_byte, input ready);
  modport sink   (input valid, input operation, input position, input data_byte,
                  input final_byte, output ready);
endinterface

interface sbr_out_if;
  logic               valid;
  logic               ready;
  logic               byte_valid;
  logic [7:0]         out_byte;
  logic               stream_done;
  logic               run_last;

  modport source (output valid, output byte_valid, output out_byte, output stream_done,
                  output run_last, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input stream_done,
                  input run_last, output ready);
endinterface

// File: sv/stream_byte_reassembler.sv
// Out-of-order stream byte reassembler: top level with sequencer, window and drain logic.
// Flow: a word is accepted in IDLE, stored in STORE (ENDREC then records the end of a
// final byte), then each drained byte passes DRAIN (slot read) and LOAD (emit); output
// stalls hold LOAD or a completion in DRAIN. A new input word is taken only in IDLE, once
// the previous word and its drained bytes are through; the slot read is registered.
// Reset: synchronous active-low rst_n clears all slot valid bits, indexes and end state.
module stream_byte_reassembler (
  input  logic            clk,
  input  logic            rst_n,
  sbr_in_if.sink          in_chan,
  sbr_out_if.source       out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_ENDREC,
    ST_DRAIN,
    ST_LOAD
  } state_t;

  localparam sbr_pkg::slot_t SLOT_LAST = sbr_pkg::SLOT_W'(sbr_pkg::CAPACITY - 1);
  localparam logic [sbr_pkg::SLOT_W:0] CAP_EXT = (sbr_pkg::SLOT_W + 1)'(sbr_pkg::CAPACITY);

  state_t                          state_r, state_nxt;
  logic                            finished_r, finished_nxt;
  logic                            end_known_r, end_known_nxt;
  sbr_pkg::pos_t                   end_len_r, end_len_nxt;
  sbr_pkg::pos_t                   next_exp_r, next_exp_nxt;
  sbr_pkg::slot_t                  next_slot_r, next_slot_nxt;
  logic [sbr_pkg::CAPACITY-1:0]    slot_valid_r, slot_valid_nxt;
  logic                            op_r, op_nxt;
  sbr_pkg::pos_t                   pos_r, pos_nxt;
  sbr_pkg::byte_t                  byte_r, byte_nxt;
  logic                            fin_r, fin_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_bvalid_r, out_bvalid_nxt;
  sbr_pkg::byte_t                  out_byte_r, out_byte_nxt;
  logic                            out_done_r, out_done_nxt;
  logic                            out_last_r, out_last_nxt;

  sbr_pkg::alu_req_t               alu_req;
  sbr_pkg::alu_rsp_t               alu_rsp;
  logic                            ram_we, ram_re;
  sbr_pkg::slot_t                  ram_waddr;
  sbr_pkg::byte_t                  ram_rdata;

  logic                            out_free, end_hit, more, in_win;
  logic [sbr_pkg::SLOT_W:0]        slot_sum;
  sbr_pkg::slot_t                  store_slot;

  sbr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sbr_ram #(
    .WIDTH (sbr_pkg::BYTE_W),
    .DEPTH (sbr_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (next_slot_r),
    .rdata (ram_rdata)
  );

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_valid  = out_bvalid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.stream_done = out_done_r;
  assign out_chan.run_last    = out_last_r;

  // Window status of the current state.
  assign out_free = !out_valid_r || out_chan.ready;
  assign end_hit  = end_known_r && (next_exp_r == end_len_r);
  assign more     = !end_hit && slot_valid_r[next_slot_r];

  // Map an in-window index to its slot; a wrapped index lies below the window size.
  assign in_win     = (alu_rsp.sum < sbr_pkg::POS_W'(sbr_pkg::CAPACITY));
  assign slot_sum   = {1'b0, next_slot_r} + {1'b0, alu_rsp.sum[sbr_pkg::SLOT_W-1:0]};
  assign store_slot = !alu_rsp.carry ? pos_r[sbr_pkg::SLOT_W-1:0] :
                      (slot_sum >= CAP_EXT) ? sbr_pkg::SLOT_W'(slot_sum - CAP_EXT) :
                      slot_sum[sbr_pkg::SLOT_W-1:0];
  assign ram_waddr  = store_slot;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    finished_nxt   = finished_r;
    end_known_nxt  = end_known_r;
    end_len_nxt    = end_len_r;
    next_exp_nxt   = next_exp_r;
    next_slot_nxt  = next_slot_r;
    slot_valid_nxt = slot_valid_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    byte_nxt       = byte_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r;
    out_bvalid_nxt = out_bvalid_r;
    out_byte_nxt   = out_byte_r;
    out_done_nxt   = out_done_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    alu_req.op     = sbr_pkg::ALU_SUB;
    alu_req.a      = pos_r;
    alu_req.b      = next_exp_r;

    // Retire the output word once taken.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // Capture a word; drop it once the stream is complete.
        if (in_chan.valid && !finished_r) begin
          op_nxt    = in_chan.operation;
          pos_nxt   = in_chan.position;
          byte_nxt  = in_chan.data_byte;
          fin_nxt   = in_chan.final_byte;
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        if (op_r == sbr_pkg::OP_END) begin
          end_known_nxt = 1'b1;
          end_len_nxt   = pos_r;
          state_nxt     = ST_DRAIN;
        end else begin
          if (in_win) begin
            ram_we                     = 1'b1;
            slot_valid_nxt[store_slot] = 1'b1;
          end
          state_nxt = fin_r ? ST_ENDREC : ST_DRAIN;
        end
      end
      ST_ENDREC: begin
        // Record the length just past the final byte.
        alu_req.op    = sbr_pkg::ALU_INC;
        end_known_nxt = 1'b1;
        end_len_nxt   = alu_rsp.sum;
        state_nxt     = ST_DRAIN;
      end
      ST_DRAIN: begin
        alu_req.op = sbr_pkg::ALU_INC;
        alu_req.a  = next_exp_r;
        if (more) begin
          // Read the next in-order slot and advance the window.
          ram_re                      = 1'b1;
          slot_valid_nxt[next_slot_r] = 1'b0;
          next_exp_nxt                = alu_rsp.sum;
          if (alu_rsp.carry || next_slot_r == SLOT_LAST) begin
            next_slot_nxt = '0;
          end else begin
            next_slot_nxt = next_slot_r + sbr_pkg::SLOT_W'(1);
          end
          state_nxt = ST_LOAD;
        end else if (end_hit) begin
          // Completion with no byte drained.
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_bvalid_nxt = 1'b0;
            out_byte_nxt   = '0;
            out_done_nxt   = 1'b1;
            out_last_nxt   = 1'b1;
            finished_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        // Emit the byte read; look ahead to mark the end of the run.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_bvalid_nxt = 1'b1;
          out_byte_nxt   = ram_rdata;
          out_done_nxt   = end_hit;
          out_last_nxt   = !more;
          if (end_hit) begin
            finished_nxt = 1'b1;
          end
          state_nxt = more ? ST_DRAIN : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      finished_r   <= 1'b0;
      end_known_r  <= 1'b0;
      end_len_r    <= '0;
      next_exp_r   <= '0;
      next_slot_r  <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      finished_r   <= finished_nxt;
      end_known_r  <= end_known_nxt;
      end_len_r    <= end_len_nxt;
      next_exp_r   <= next_exp_nxt;
      next_slot_r  <= next_slot_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    byte_r       <= byte_nxt;
    fin_r        <= fin_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_byte_r   <= out_byte_nxt;
    out_done_r   <= out_done_nxt;
    out_last_r   <= out_last_nxt;
  end

  // No new result once the stream is complete.
  a_no_word_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r && !out_valid_r |=> !out_valid_r)
    else $error("result word raised after stream completion");

  // Completion always closes the run.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("stream_done without run_last");

  // A word without a byte is only the completion word.
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bvalid_r |-> out_done_r && out_byte_r == '0)
    else $error("empty result word that is not a completion");

  // Completion is flagged together with its result word.
  a_finish_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> out_valid_r && out_done_r)
    else $error("stream finished without a completion word");

endmodule

// File: sv/sbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sbr_alu.sv
// Shared 32-bit index adder: subtract for window offsets, increment for indexes.
module sbr_alu (
  input  sbr_pkg::alu_req_t req,
  output sbr_pkg::alu_rsp_t rsp
);

  logic [sbr_pkg::POS_W:0] full;

  // Carry out of a subtract is set when no borrow occurred.
  always_comb begin
    unique case (req.op)
      sbr_pkg::ALU_SUB: full = {1'b0, req.a} + {1'b0, ~req.b} + {{sbr_pkg::POS_W{1'b0}}, 1'b1};
      sbr_pkg::ALU_INC: full = {1'b0, req.a} + {{sbr_pkg::POS_W{1'b0}}, 1'b1};
      default:          full = '0;
    endcase
    rsp.sum   = full[sbr_pkg::POS_W-1:0];
    rsp.carry = full[sbr_pkg::POS_W];
  end

endmodule

// File: bench/stream_byte_reassembler_tb.sv
// Testbench for the stream byte reassembler: directed words, random out-of-order traffic, then closing directed words.
module stream_byte_reassembler_tb;

  localparam int RANDOM_WORDS    = 150;
  localparam int FILL_AT         = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    sbr_pkg::op_code_t op;
    sbr_pkg::pos_t     pos;
    sbr_pkg::byte_t    data;
    logic              fin;
  } in_word_t;

  typedef struct packed {
    logic           byte_valid;
    sbr_pkg::byte_t data;
    logic           done;
    logic           run_end;
  } out_word_t;

  typedef struct packed {
    sbr_pkg::op_code_t op;
    logic              rel;     // position counts from the next expected index
    sbr_pkg::pos_t     pos;
    sbr_pkg::byte_t    data;
    logic              fin;
    logic              chk;     // typed result below is compared
    logic [6:0]        n;
    out_word_t         res;
  } plan_row_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_SPARSE,
    RX_BURSTY
  } stall_mode_t;

  localparam out_word_t NO_RESULT = '0;
  localparam int PLAN_ROWS = 22;
  localparam int OPEN_ROWS = 16;

  // Opening rows run right after reset; closing rows end the stream.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // out of order byte, held until index 0 arrives
    '{sbr_pkg::OP_DATA, 1'b0, 32'd1, 8'h11, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'd2, 8'hFF, 1'b0, 1'b1, 7'd1, '{1'b1, 8'hFF, 1'b0, 1'b1}},
    // behind the window
    '{sbr_pkg::OP_DATA, 1'b0, 32'd0, 8'h55, 1'b0, 1'b1, 7'd0, NO_RESULT},
    // final byte at the top index: end wraps to zero and is already passed
    '{sbr_pkg::OP_DATA, 1'b0, 32'hFFFF_FFFF, 8'hAA, 1'b1, 1'b1, 7'd0, NO_RESULT},
    // last slot of the window, then just past it
    '{sbr_pkg::OP_DATA, 1'b0, sbr_pkg::pos_t'(sbr_pkg::CAPACITY + 2), 8'h42, 1'b0, 1'b1,
      7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, sbr_pkg::pos_t'(sbr_pkg::CAPACITY + 3), 8'h24, 1'b0, 1'b1,
      7'd0, NO_RESULT},
    // rewrite of a stored index, the later byte wins
    '{sbr_pkg::OP_DATA, 1'b0, 32'd4, 8'h01, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'd4, 8'h02, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'd3, 8'h7E, 1'b0, 1'b0, 7'd0, NO_RESULT},
    // end markers far ahead and behind, each overwriting the last
    '{sbr_pkg::OP_END,  1'b0, 32'h8000_0000, 8'h00, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_END,  1'b0, 32'd2, 8'hFF, 1'b1, 1'b1, 7'd0, NO_RESULT},
    // final byte outside the window still records the end
    '{sbr_pkg::OP_DATA, 1'b0, 32'h7FFF_FFFF, 8'h00, 1'b1, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_END,  1'b0, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'h8000_0005, 8'h5A, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b0, 32'd5, 8'hC3, 1'b0, 1'b1, 7'd1, '{1'b1, 8'hC3, 1'b0, 1'b1}},
    // closing: bytes past the end are stored but never delivered
    '{sbr_pkg::OP_DATA, 1'b1, 32'd2, 8'h3C, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b1, 32'd5, 8'hE1, 1'b0, 1'b1, 7'd0, NO_RESULT},
    // end at the next index: completion without a byte
    '{sbr_pkg::OP_END,  1'b1, 32'd0, 8'h00, 1'b0, 1'b1, 7'd1, '{1'b0, 8'h00, 1'b1, 1'b1}},
    // after completion every word is ignored
    '{sbr_pkg::OP_DATA, 1'b1, 32'd0, 8'h99, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_END,  1'b1, 32'd1, 8'h00, 1'b0, 1'b1, 7'd0, NO_RESULT},
    '{sbr_pkg::OP_DATA, 1'b1, 32'd1, 8'h66, 1'b1, 1'b1, 7'd0, NO_RESULT}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sbr_in_if  in_chan();
  sbr_out_if out_chan();

  stream_byte_reassembler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Local copy of the reassembly state
  logic [sbr_pkg::CAPACITY-1:0][7:0] slot_data;
  logic [sbr_pkg::CAPACITY-1:0]      slot_full;
  sbr_pkg::pos_t                     next_pos;
  logic                              end_seen;
  sbr_pkg::pos_t                     end_pos;
  logic                              stream_over;

  out_word_t pending_deliveries[$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  words_sent      = 0;
  int  longest_drain   = 0;
  int  burst_left      = 0;
  int  quiet_cycles    = 0;
  bit  hold_off_req    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string fmt(input out_word_t r);
    return $sformatf("valid=%0b byte=%02h done=%0b last=%0b",
                     r.byte_valid, r.data, r.done, r.run_end);
  endfunction

  function automatic void note_error(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endfunction

  // Apply one word to the reassembly state and work out the bytes it releases.
  // State and expectations change only when commit is set.
  function automatic int reassemble(input in_word_t w, input bit commit, output bit completes);
    logic [sbr_pkg::CAPACITY-1:0][7:0] data_v;
    logic [sbr_pkg::CAPACITY-1:0]      full_v;
    sbr_pkg::pos_t                     nxt;
    logic                              known;
    sbr_pkg::pos_t                     len;
    out_word_t                         res[$];
    sbr_pkg::pos_t                     offset;
    int                                s;
    data_v    = slot_data;
    full_v    = slot_full;
    nxt       = next_pos;
    known     = end_seen;
    len       = end_pos;
    completes = 1'b0;
    if (stream_over) return 0;
    // store the byte or record the end
    if (w.op == sbr_pkg::OP_END) begin
      known = 1'b1;
      len   = w.pos;
    end else begin
      offset = w.pos - nxt;
      if (offset < sbr_pkg::CAPACITY) begin
        s = int'(w.pos % sbr_pkg::CAPACITY);
        data_v[s] = w.data;
        full_v[s] = 1'b1;
      end
      if (w.fin) begin
        known = 1'b1;
        len   = w.pos + 1;
      end
    end
    // drain the contiguous run, stopping at the end of the stream
    while (res.size() < sbr_pkg::CAPACITY && !(known && nxt == len) &&
           full_v[int'(nxt % sbr_pkg::CAPACITY)]) begin
      s = int'(nxt % sbr_pkg::CAPACITY);
      res.push_back(out_word_t'{1'b1, data_v[s], 1'b0, 1'b0});
      full_v[s] = 1'b0;
      nxt++;
    end
    if (known && nxt == len) begin
      completes = 1'b1;
      if (res.size() == 0) res.push_back(out_word_t'{1'b0, 8'h00, 1'b1, 1'b1});
      else res[res.size()-1].done = 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].run_end = 1'b1;
    if (commit) begin
      slot_data   = data_v;
      slot_full   = full_v;
      next_pos    = nxt;
      end_seen    = known;
      end_pos     = len;
      stream_over = stream_over | completes;
      foreach (res[i]) pending_deliveries.push_back(res[i]);
      if (res.size() > longest_drain) longest_drain = res.size();
    end
    return res.size();
  endfunction

  // Offer one word in bursts with random gaps; predict at acceptance.
  task automatic push_word(input in_word_t w, output int produced);
    int gap;
    bit closes;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= w.op;
    in_chan.position   <= w.pos;
    in_chan.data_byte  <= w.data;
    in_chan.final_byte <= w.fin;
    do @(posedge clk); while (!in_chan.ready);
    produced = reassemble(w, 1'b1, closes);
    words_sent++;
  endtask

  // Keep the stream open during the random part: a word that would complete
  // the stream is swapped for a byte just past the window.
  task automatic offer_word(input in_word_t w);
    bit closes;
    int n;
    void'(reassemble(w, 1'b0, closes));
    if (closes) begin
      w.op  = sbr_pkg::OP_DATA;
      w.fin = 1'b0;
      w.pos = next_pos + sbr_pkg::CAPACITY;
    end
    push_word(w, n);
  endtask

  task automatic walk_row(input plan_row_t r);
    in_word_t w;
    int       n;
    w.op   = r.op;
    w.pos  = r.rel ? next_pos + r.pos : r.pos;
    w.data = r.data;
    w.fin  = r.fin;
    push_word(w, n);
    if (r.chk && (n != r.n || (n == 1 && pending_deliveries[$] !== r.res)))
      note_error($sformatf("table word pos=%08h: model gives %0d results, table %0d (%s)",
                           w.pos, n, r.n, fmt(r.res)));
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.op   = sbr_pkg::OP_DATA;
    w.data = sbr_pkg::byte_t'($urandom);
    w.fin  = 1'b0;
    pick   = $urandom_range(0, 99);
    if (pick < 35)      w.pos = next_pos;
    else if (pick < 65) w.pos = next_pos + $urandom_range(1, 15);
    else if (pick < 75) w.pos = next_pos + $urandom_range(16, sbr_pkg::CAPACITY - 1);
    else if (pick < 80) w.pos = next_pos + $urandom_range(sbr_pkg::CAPACITY,
                                                          sbr_pkg::CAPACITY + 3);
    else if (pick < 85) w.pos = next_pos - $urandom_range(1, 200);
    else if (pick < 93) begin
      w.pos = $urandom;
      w.fin = 1'($urandom_range(0, 1));
    end else begin
      w.op  = sbr_pkg::OP_END;
      w.pos = $urandom_range(0, 1) ? sbr_pkg::pos_t'($urandom) :
                                     next_pos - $urandom_range(1, 200);
    end
    return w;
  endfunction

  // Receiver: rotate through stall patterns, with one long hold-off on request
  initial begin : receiver
    int unsigned phase;
    stall_mode_t mode;
    phase = 0;
    mode  = RX_STEADY;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      phase++;
      if (phase % 50 == 0) mode = stall_mode_t'($urandom_range(0, 3));
      case (mode)
        RX_STEADY: out_chan.ready <= 1'b1;
        RX_RANDOM: out_chan.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_chan.ready <= (phase % 4 != 0);
        default:   out_chan.ready <= (phase % 9 < 3);
      endcase
    end
  end

  // Compare every delivered word with the oldest expectation
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.byte_valid, out_chan.out_byte, out_chan.stream_done, out_chan.run_last};
      if (pending_deliveries.size() == 0) begin
        note_error($sformatf("unexpected result: %s", fmt(got)));
      end else begin
        want = pending_deliveries.pop_front();
        results_checked++;
        if (got !== want)
          note_error($sformatf("result %0d: expected %s, got %s",
                               results_checked, fmt(want), fmt(got)));
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_deliveries.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    sbr_pkg::pos_t base;
    in_word_t      w;
    in_chan.valid      = 1'b0;
    in_chan.operation  = sbr_pkg::OP_DATA;
    in_chan.position   = '0;
    in_chan.data_byte  = '0;
    in_chan.final_byte = 1'b0;
    slot_data   = '0;
    slot_full   = '0;
    next_pos    = '0;
    end_seen    = 1'b0;
    end_pos     = '0;
    stream_over = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OPEN_ROWS; i++) walk_row(PLAN[i]);

    // Random traffic, with one full-window fill drained under receiver hold-off
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == FILL_AT) begin
        base = next_pos;
        for (int j = sbr_pkg::CAPACITY - 1; j >= 1; j--) begin
          w = '{sbr_pkg::OP_DATA, base + sbr_pkg::pos_t'(j), sbr_pkg::byte_t'($urandom), 1'b0};
          offer_word(w);
        end
        hold_off_req = 1'b1;
        w = '{sbr_pkg::OP_DATA, base, sbr_pkg::byte_t'($urandom), 1'b0};
        offer_word(w);
      end
      offer_word(random_word());
    end

    for (int i = OPEN_ROWS; i < PLAN_ROWS; i++) walk_row(PLAN[i]);
    in_chan.valid <= 1'b0;

    // Drain what is still owed, then give the block time to show extras
    while (pending_deliveries.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d words accepted (%0d from the table), %0d results checked.",
             words_sent, PLAN_ROWS, results_checked);
    $display("Summary: longest drain %0d bytes, one %0d-cycle receiver hold-off.",
             longest_drain, HOLD_OFF_CYCLES);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
